### hw/rtl/stq_pkg.sv
// shared constants, codes and types of the sorted timer queue
`default_nettype none

package stq_pkg;

   localparam int DEPTH     = 16;
   localparam int TIME_BITS = 32;
   localparam int ID_BITS   = 8;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // request codes
   typedef enum logic [1:0] {
      REQ_ADD  = 2'd0,
      REQ_DEL  = 2'd1,
      REQ_ADJ  = 2'd2,
      REQ_TICK = 2'd3
   } req_code_type;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_FULL   = 2'd1,
      STS_ABSENT = 2'd2,
      STS_DUP    = 2'd3
   } status_code_type;

   // operands of the request being worked on, broadcast to every cell
   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] exp;
      logic [TIME_BITS-1:0] now;
   } stq_key_type;

   // per-cycle command to the cell row
   typedef struct packed {
      logic look;   // register match and expired flags
      logic ins;    // sorted insert of the broadcast key
      logic del;    // remove the matching entry, close the gap
      logic pop;    // drop the front entry, whole row moves forward
   } stq_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/stq_if.sv
// valid/ready channel interfaces for requests and responses
`default_nettype none

interface stq_req_if
   import stq_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [ID_BITS-1:0]   timer_id;
   logic [TIME_BITS-1:0] expire_time;
   logic [TIME_BITS-1:0] now_time;

   modport source (output valid, req_type, timer_id, expire_time, now_time, input ready);
   modport sink (input valid, req_type, timer_id, expire_time, now_time, output ready);
endinterface

interface stq_rsp_if
   import stq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ID_BITS-1:0]  out_id;
   logic                fired;
   logic [1:0]          status;
   logic                last;
   logic [CNT_BITS-1:0] occupancy;

   modport source (output valid, out_id, fired, status, last, occupancy, input ready);
   modport sink (input valid, out_id, fired, status, last, occupancy, output ready);
endinterface

`default_nettype wire

### hw/rtl/stq_cell.sv
// one slot of the sorted timer row: holds a handle and its expiry
`default_nettype none

module stq_cell
   import stq_pkg::*;
(
   input  wire logic                 clock,
   input  wire stq_ctl_type          ctl,
   input  wire stq_key_type          key,
   input  wire logic                 valid,
   input  wire logic                 front_le,
   input  wire logic                 left_after,
   input  wire logic [ID_BITS-1:0]   left_id,
   input  wire logic [TIME_BITS-1:0] left_exp,
   input  wire logic [ID_BITS-1:0]   right_id,
   input  wire logic [TIME_BITS-1:0] right_exp,
   input  wire logic                 shift_in,
   output logic [ID_BITS-1:0]        cell_id,
   output logic [TIME_BITS-1:0]      cell_exp,
   output logic                      after,
   output logic                      match,
   output logic                      expired,
   output logic                      shift_out
);

   logic [ID_BITS-1:0]   id_ff;
   logic [TIME_BITS-1:0] exp_ff;
   logic                 match_ff;
   logic                 expired_ff;

   // new key belongs behind this entry
   assign after     = valid && (exp_ff <= key.exp) && !front_le;
   // removal gap starts at the matching cell and runs to the tail
   assign shift_out = shift_in | match_ff;

   // slot contents
   always_ff @(posedge clock) begin
      if (ctl.ins) begin
         if (!after) begin
            if (left_after) begin
               id_ff  <= key.id;
               exp_ff <= key.exp;
            end else begin
               id_ff  <= left_id;
               exp_ff <= left_exp;
            end
         end
      end else if (ctl.pop || (ctl.del && shift_out)) begin
         id_ff  <= right_id;
         exp_ff <= right_exp;
      end
   end

   // lookup flags
   always_ff @(posedge clock) begin
      if (ctl.look) begin
         match_ff   <= valid && (id_ff == key.id);
         expired_ff <= valid && (exp_ff <= key.now);
      end
   end

   assign cell_id  = id_ff;
   assign cell_exp = exp_ff;
   assign match    = match_ff;
   assign expired  = expired_ff;

endmodule

`default_nettype wire

### hw/rtl/sorted_timer_queue.sv
// Sorted timer queue: a row of DEPTH cells keeps the timers in expiry order,
// front first, and every cell compares its own entry against the broadcast
// request, so an insert or a removal moves every entry behind its place by one
// place together. One request is worked on at a time. Add and delete pass
// through lookup, execute and response states, register their response and
// then take the next request; adjust adds a sorted insert state after the
// removal (remove, then sorted insert). A tick sends its results from the pop
// state, one per cycle while the response slot is free, one per expired timer
// or a single empty result. Backpressure on the response channel holds the
// response and pop states. There is no reset sweep; the occupancy count alone
// marks which cells hold timers.
`default_nettype none

module sorted_timer_queue
   import stq_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   stq_req_if.sink   req_chan,
   stq_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_EXEC,
      S_INS,
      S_RESP,
      S_POP
   } state_type;

   state_type           state_ff;
   req_code_type        op_ff;
   stq_key_type         key_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] pop_left_ff;
   status_code_type     status_ff;

   logic                rsp_valid_ff;
   logic [ID_BITS-1:0]  rsp_id_ff;
   logic                rsp_fired_ff;
   logic [1:0]          rsp_status_ff;
   logic                rsp_last_ff;
   logic [CNT_BITS-1:0] rsp_occ_ff;

   stq_ctl_type          ctl;
   logic [ID_BITS-1:0]   cell_id  [DEPTH];
   logic [TIME_BITS-1:0] cell_exp [DEPTH];
   logic [DEPTH-1:0]     cell_valid;
   logic [DEPTH-1:0]     after;
   logic [DEPTH-1:0]     match;
   logic [DEPTH-1:0]     expired;
   logic [DEPTH:0]       shift;
   logic                 front_le;
   logic                 hit;
   logic                 full;
   logic                 out_free;
   logic [CNT_BITS-1:0]  npop;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign hit            = |match;
   assign full           = (count_ff == CNT_BITS'(DEPTH));
   assign front_le       = (count_ff == '0) || (key_ff.exp <= cell_exp[0]);
   assign shift[0]       = 1'b0;

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 l_after;
      logic [ID_BITS-1:0]   l_id;
      logic [TIME_BITS-1:0] l_exp;
      logic [ID_BITS-1:0]   r_id;
      logic [TIME_BITS-1:0] r_exp;

      assign cell_valid[i] = (count_ff > CNT_BITS'(i));

      if (i == 0) begin : g_head
         assign l_after = 1'b1;
         assign l_id    = key_ff.id;
         assign l_exp   = key_ff.exp;
      end else begin : g_body
         assign l_after = after[i-1];
         assign l_id    = cell_id[i-1];
         assign l_exp   = cell_exp[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_id  = cell_id[i];
         assign r_exp = cell_exp[i];
      end else begin : g_next
         assign r_id  = cell_id[i+1];
         assign r_exp = cell_exp[i+1];
      end

      stq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (key_ff),
         .valid      (cell_valid[i]),
         .front_le   (front_le),
         .left_after (l_after),
         .left_id    (l_id),
         .left_exp   (l_exp),
         .right_id   (r_id),
         .right_exp  (r_exp),
         .shift_in   (shift[i]),
         .cell_id    (cell_id[i]),
         .cell_exp   (cell_exp[i]),
         .after      (after[i]),
         .match      (match[i]),
         .expired    (expired[i]),
         .shift_out  (shift[i+1])
      );
   end

   // expired cells form a prefix; encode the edge of that prefix
   always_comb begin
      npop = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (expired[i] && ((i == DEPTH - 1) || !expired[(i + 1) % DEPTH])) begin
            npop = npop | CNT_BITS'(i + 1);
         end
      end
   end

   // row commands
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_LOOK: ctl.look = 1'b1;
         S_EXEC: begin
            unique case (op_ff)
               REQ_ADD:  ctl.ins = !hit && !full;
               REQ_DEL,
               REQ_ADJ:  ctl.del = hit;
               REQ_TICK: ctl = '0;
            endcase
         end
         S_INS:  ctl.ins = 1'b1;
         S_POP:  ctl.pop = out_free && (pop_left_ff != '0);
         S_IDLE,
         S_RESP: ctl = '0;
      endcase
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response slot frees up unless a new result is loaded below
         if (out_free && (state_ff != S_RESP) && (state_ff != S_POP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  op_ff      <= req_code_type'(req_chan.req_type);
                  key_ff.id  <= req_chan.timer_id;
                  key_ff.exp <= req_chan.expire_time;
                  key_ff.now <= req_chan.now_time;
                  state_ff   <= S_LOOK;
               end
            end
            S_LOOK: state_ff <= S_EXEC;
            S_EXEC: begin
               unique case (op_ff)
                  REQ_ADD: begin
                     state_ff <= S_RESP;
                     if (hit) begin
                        status_ff <= STS_DUP;
                     end else if (full) begin
                        status_ff <= STS_FULL;
                     end else begin
                        status_ff <= STS_OK;
                        count_ff  <= count_ff + 1'b1;
                     end
                  end
                  REQ_DEL: begin
                     state_ff <= S_RESP;
                     if (hit) begin
                        status_ff <= STS_OK;
                        count_ff  <= count_ff - 1'b1;
                     end else begin
                        status_ff <= STS_ABSENT;
                     end
                  end
                  REQ_ADJ: begin
                     if (hit) begin
                        status_ff <= STS_OK;
                        count_ff  <= count_ff - 1'b1;
                        state_ff  <= S_INS;
                     end else begin
                        status_ff <= STS_ABSENT;
                        state_ff  <= S_RESP;
                     end
                  end
                  REQ_TICK: begin
                     status_ff   <= STS_OK;
                     count_ff    <= count_ff - npop;
                     pop_left_ff <= npop;
                     state_ff    <= S_POP;
                  end
               endcase
            end
            S_INS: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_id_ff     <= key_ff.id;
                  rsp_fired_ff  <= 1'b0;
                  rsp_status_ff <= status_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_occ_ff    <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            S_POP: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= STS_OK;
                  rsp_occ_ff    <= count_ff;
                  if (pop_left_ff == '0) begin
                     // nothing expired
                     rsp_id_ff    <= '0;
                     rsp_fired_ff <= 1'b0;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     rsp_id_ff    <= cell_id[0];
                     rsp_fired_ff <= 1'b1;
                     rsp_last_ff  <= (pop_left_ff == CNT_BITS'(1));
                     pop_left_ff  <= pop_left_ff - 1'b1;
                     if (pop_left_ff == CNT_BITS'(1)) begin
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_id    = rsp_id_ff;
   assign rsp_chan.fired     = rsp_fired_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.last      = rsp_last_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;

endmodule

`default_nettype wire

### hw/rtl/stq_checker.sv
// port-level checks of the sorted timer queue and their bind
`default_nettype none

module stq_checker
   import stq_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [ID_BITS-1:0]  rsp_out_id,
   input wire logic                rsp_fired,
   input wire logic [1:0]          rsp_status,
   input wire logic                rsp_last,
   input wire logic [CNT_BITS-1:0] rsp_occupancy
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_id) && $stable(rsp_last))
      else $error("response changed while stalled");

   // an expired timer always reports ok
   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_status == STS_OK)
      else $error("fired response with error status");

   // only tick bursts have results before the last one
   a_not_last_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_fired)
      else $error("non-last response that is not a fired timer");

   // the count never passes the capacity, and a pop leaves room
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNT_BITS'(DEPTH))
                    && (!rsp_fired || rsp_occupancy != CNT_BITS'(DEPTH)))
      else $error("occupancy out of range");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_id    (rsp_chan.out_id),
   .rsp_fired     (rsp_chan.fired),
   .rsp_status    (rsp_chan.status),
   .rsp_last      (rsp_chan.last),
   .rsp_occupancy (rsp_chan.occupancy)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the sorted timer queue with directed and random traffic
module tb;
   import stq_pkg::*;

   typedef struct {
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] exp;
   } timer_entry_type;

   typedef struct {
      logic [ID_BITS-1:0]  out_id;
      logic                fired;
      status_code_type     status;
      logic                last;
      logic [CNT_BITS-1:0] occupancy;
   } timer_rsp_type;

   logic clock = 1'b0;
   logic reset;

   stq_req_if req_chan();
   stq_rsp_if rsp_chan();

   sorted_timer_queue i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // timers held by the queue, front first, and the results still owed
   timer_entry_type      timer_list[$];
   timer_rsp_type        expected_rsp[$];
   int                   mismatches    = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   logic [TIME_BITS-1:0] wall_time;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the queue hangs
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver stalls, changed on the falling edge
   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // compare every result transfer with the oldest expected one
   always @(posedge clock) begin : check_results
      timer_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("out_id: expected no result, actual %0d", rsp_chan.out_id);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("out_id", want.out_id, rsp_chan.out_id);
            check_field("fired", want.fired, rsp_chan.fired);
            check_field("status", want.status, rsp_chan.status);
            check_field("last", want.last, rsp_chan.last);
            check_field("occupancy", want.occupancy, rsp_chan.occupancy);
         end
      end
   end

   // sorted insert: in front on equal front expiry, else after equal entries
   function automatic void insert_timer(input logic [ID_BITS-1:0] id,
                                        input logic [TIME_BITS-1:0] exp);
      timer_entry_type entry;
      int              pos;
      entry.id  = id;
      entry.exp = exp;
      if (timer_list.size() == 0 || exp <= timer_list[0].exp) begin
         pos = 0;
      end else begin
         pos = 1;
         while (pos < timer_list.size() && timer_list[pos].exp <= exp) pos++;
      end
      timer_list.insert(pos, entry);
   endfunction

   // work out the results of one accepted request and update the timer list
   function automatic void predict_timer_step(input req_code_type kind,
                                              input logic [ID_BITS-1:0] id,
                                              input logic [TIME_BITS-1:0] exp,
                                              input logic [TIME_BITS-1:0] now);
      logic [ID_BITS-1:0] fired_ids[$];
      status_code_type    sts;
      int                 slot;
      timer_rsp_type      rsp;
      sts = STS_OK;
      if (kind == REQ_TICK) begin
         while (timer_list.size() > 0 && timer_list[0].exp <= now) begin
            fired_ids.push_back(timer_list[0].id);
            void'(timer_list.pop_front());
         end
         if (fired_ids.size() == 0) begin
            rsp = '{out_id: '0, fired: 1'b0, status: STS_OK, last: 1'b1,
                    occupancy: CNT_BITS'(timer_list.size())};
            expected_rsp.push_back(rsp);
         end
         foreach (fired_ids[i]) begin
            rsp = '{out_id: fired_ids[i], fired: 1'b1, status: STS_OK,
                    last: (i == fired_ids.size() - 1),
                    occupancy: CNT_BITS'(timer_list.size())};
            expected_rsp.push_back(rsp);
         end
      end else begin
         slot = -1;
         foreach (timer_list[i]) begin
            if (slot < 0 && timer_list[i].id == id) slot = i;
         end
         if (kind == REQ_ADD) begin
            if (slot >= 0) sts = STS_DUP;
            else if (timer_list.size() >= DEPTH) sts = STS_FULL;
            else insert_timer(id, exp);
         end else if (slot < 0) begin
            sts = STS_ABSENT;
         end else begin
            timer_list.delete(slot);
            if (kind == REQ_ADJ) insert_timer(id, exp);
         end
         rsp = '{out_id: id, fired: 1'b0, status: sts, last: 1'b1,
                 occupancy: CNT_BITS'(timer_list.size())};
         expected_rsp.push_back(rsp);
      end
   endfunction

   // one request transfer, with random sender gaps ahead of it
   task automatic send_request(input req_code_type kind, input logic [ID_BITS-1:0] id,
                               input logic [TIME_BITS-1:0] exp,
                               input logic [TIME_BITS-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.req_type    = kind;
      req_chan.timer_id    = id;
      req_chan.expire_time = exp;
      req_chan.now_time    = now;
      do @(posedge clock); while (!req_chan.ready);
      predict_timer_step(kind, id, exp, now);
   endtask

   // stop sending until every owed result has come back
   task automatic wait_until_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // empty queue, absent handles, extremes, duplicates and equal expiries
   task automatic test_edge_cases();
      send_request(REQ_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_DEL, 8'd7, 32'd0, 32'd0);
      send_request(REQ_ADJ, 8'd9, 32'd5, 32'd0);
      send_request(REQ_ADD, 8'd0, 32'd0, 32'hFFFF_FFFF);
      send_request(REQ_ADD, 8'hFF, 32'hFFFF_FFFF, 32'd0);
      send_request(REQ_ADD, 8'd0, 32'd10, 32'd0);
      // equal to the front goes in front, elsewhere after the equal ones
      send_request(REQ_ADD, 8'd1, 32'd0, 32'd0);
      send_request(REQ_ADD, 8'd2, 32'd100, 32'd0);
      send_request(REQ_ADD, 8'd3, 32'd100, 32'd0);
      send_request(REQ_ADJ, 8'hFF, 32'd50, 32'd0);
      send_request(REQ_DEL, 8'd2, 32'd0, 32'd0);
      // two front timers fire, then nothing is due
      send_request(REQ_TICK, 8'hAA, 32'd0, 32'd0);
      send_request(REQ_TICK, 8'd0, 32'd0, 32'd49);
   endtask

   // fill up, add two absent handles to the full queue, then fire everything
   task automatic test_full_queue();
      for (int k = timer_list.size(); k < DEPTH; k++) begin
         send_request(REQ_ADD, ID_BITS'(16 + k), $urandom_range(1000), $urandom());
      end
      send_request(REQ_ADD, 8'd200, 32'd1, 32'd0);
      send_request(REQ_ADD, 8'd16, 32'd1, 32'd0);
      send_request(REQ_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
   endtask

   // random mix of adds, deletes, adjusts and ticks around a running clock
   task automatic test_random_traffic(input int n_items);
      int unsigned          pick;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] exp;
      logic [TIME_BITS-1:0] now;
      repeat (n_items) begin
         pick = $urandom_range(99);
         id   = ID_BITS'($urandom());
         // mostly held handles for delete and adjust, a few for add
         if (timer_list.size() > 0 && $urandom_range(99) < (pick < 40 ? 10 : 80))
            id = timer_list[$urandom_range(timer_list.size() - 1)].id;
         exp = ($urandom_range(19) == 0) ? $urandom() : wall_time + $urandom_range(300);
         now = ($urandom_range(19) == 0) ? $urandom() : wall_time + $urandom_range(150);
         if (pick < 40) begin
            send_request(REQ_ADD, id, exp, $urandom());
         end else if (pick < 55) begin
            send_request(REQ_DEL, id, $urandom(), $urandom());
         end else if (pick < 70) begin
            send_request(REQ_ADJ, id, exp, $urandom());
         end else begin
            send_request(REQ_TICK, ID_BITS'($urandom()), $urandom(), now);
            wall_time = now;
         end
         // now and then hold off until the queue has answered everything
         if ($urandom_range(19) == 0) wait_until_drained();
      end
   endtask

   // reset, tests in turn, drain and verdict
   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_ADD;
      req_chan.timer_id    = '0;
      req_chan.expire_time = '0;
      req_chan.now_time    = '0;
      rsp_chan.ready       = 1'b0;
      wall_time            = $urandom();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 56;
      test_edge_cases();
      test_full_queue();
      test_random_traffic(30);
      wait_until_drained();

      send_idle_pct = 56;
      recv_idle_pct = 28;
      test_random_traffic(30);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(30);

      wait_until_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
